// ===== design/obb_sat_pkg.sv =====
// ----------------------------------------------------------------------------
// obb_sat_pkg
// Shared types, widths and helpers for the oriented-box separating axis test.
// ----------------------------------------------------------------------------
package obb_sat_pkg;

    localparam int W    = 16;             // component width
    localparam int CF   = W / 2;          // center / extent fraction bits
    localparam int AF   = W - 2;          // axis fraction bits
    localparam int FW   = 48;             // field width
    localparam int DW   = W + 1;          // center difference width
    localparam int PW   = DW + W + 2;     // projection width (dot of 3)
    localparam int RW   = 2 * W + 2 - AF; // floored axis dot width
    localparam int TW   = PW - AF;        // floored projection width
    localparam int MW   = TW + RW;        // edge product width
    localparam int SW   = 2 * W + 6;      // rhs sum width (unsigned)
    localparam int LW   = MW + 1;         // edge lhs width

    typedef logic signed [W-1:0]  comp_t;
    typedef logic        [W-1:0]  ucomp_t;
    typedef logic signed [DW-1:0] diff_t;
    typedef logic signed [PW-1:0] proj_t;
    typedef logic signed [RW-1:0] rot_t;
    typedef logic        [RW-1:0] urot_t;
    typedef logic signed [TW-1:0] tproj_t;
    typedef logic signed [MW-1:0] prod_t;
    typedef logic        [SW-1:0] sum_t;
    typedef logic        [LW-1:0] lhs_t;
    typedef logic        [3:0]    axis_id_t;

    localparam axis_id_t AXIS_NONE = 4'd0;

    function automatic comp_t get_s(input logic [FW-1:0] word, input int k);
        return comp_t'(word[k*W +: W]);
    endfunction

    function automatic ucomp_t get_u(input logic [FW-1:0] word, input int k);
        return word[k*W +: W];
    endfunction

endpackage

// ===== design/obb_sat_if.sv =====
// ----------------------------------------------------------------------------
// obb_sat_in_if / obb_sat_out_if
// Valid/ready channels carrying box pair requests and test results.
// ----------------------------------------------------------------------------
interface obb_sat_in_if;
    import obb_sat_pkg::*;
    logic          valid;
    logic          ready;
    logic [FW-1:0] center_a;
    logic [FW-1:0] center_b;
    logic [FW-1:0] axis_a0;
    logic [FW-1:0] axis_a1;
    logic [FW-1:0] axis_a2;
    logic [FW-1:0] axis_b0;
    logic [FW-1:0] axis_b1;
    logic [FW-1:0] axis_b2;
    logic [FW-1:0] extents_a;
    logic [FW-1:0] extents_b;
    modport source (output valid, center_a, center_b, axis_a0, axis_a1, axis_a2,
                    axis_b0, axis_b1, axis_b2, extents_a, extents_b, input ready);
    modport sink   (input valid, center_a, center_b, axis_a0, axis_a1, axis_a2,
                    axis_b0, axis_b1, axis_b2, extents_a, extents_b, output ready);
endinterface

interface obb_sat_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] separating_axis;
    modport source (output valid, separating_axis, input ready);
    modport sink   (input valid, separating_axis, output ready);
endinterface

// ===== design/obb_separating_axis_test_top.sv =====
// ----------------------------------------------------------------------------
// obb_separating_axis_test_top
// Fifteen-axis oriented-box overlap test, fully pipelined.
// ----------------------------------------------------------------------------
// Accepts one box pair per cycle while the result side does not stall and
// returns its result in an output register after six register stages (unpack,
// products, sums, radii products, compares, output). A stall on the result
// side freezes the whole pipeline; ready follows the output register.
module obb_separating_axis_test_top
    import obb_sat_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    obb_sat_in_if.sink    in_ch,
    obb_sat_out_if.source out_ch
);
    localparam int NST = 5;
    logic [NST-1:0] vld_reg;
    logic           ovld_reg;
    axis_id_t       oaxis_reg;
    logic           en;
    proj_t          pa [3];
    proj_t          pb [3];
    rot_t           r  [3][3];
    ucomp_t         ea [3];
    ucomp_t         eb [3];
    axis_id_t       axis_id;

    assign en          = !ovld_reg || out_ch.ready;
    assign in_ch.ready = en;

    obb_sat_dot u_dot (
        .clk(clk), .en(en),
        .center_a(in_ch.center_a), .center_b(in_ch.center_b),
        .axis_a0(in_ch.axis_a0), .axis_a1(in_ch.axis_a1), .axis_a2(in_ch.axis_a2),
        .axis_b0(in_ch.axis_b0), .axis_b1(in_ch.axis_b1), .axis_b2(in_ch.axis_b2),
        .extents_a(in_ch.extents_a), .extents_b(in_ch.extents_b),
        .pa(pa), .pb(pb), .r(r), .ea(ea), .eb(eb)
    );

    obb_sat_test u_test (
        .clk(clk), .en(en), .pa(pa), .pb(pb), .r(r), .ea(ea), .eb(eb),
        .axis_id(axis_id)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            ovld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg  <= {vld_reg[NST-2:0], in_ch.valid};
            ovld_reg <= vld_reg[NST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            oaxis_reg <= axis_id;
    end

    assign out_ch.valid           = ovld_reg;
    assign out_ch.separating_axis = oaxis_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.separating_axis))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("pipeline stalled with empty output");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[NST-1] |=> out_ch.valid)
        else $error("request lost at output");
endmodule

// ===== design/obb_sat_dot.sv =====
// ----------------------------------------------------------------------------
// obb_sat_dot
// Stage 1-2: unpack, center difference, and all dot products.
// ----------------------------------------------------------------------------
module obb_sat_dot
    import obb_sat_pkg::*;
(
    input  logic          clk,
    input  logic          en,
    input  logic [FW-1:0] center_a,
    input  logic [FW-1:0] center_b,
    input  logic [FW-1:0] axis_a0,
    input  logic [FW-1:0] axis_a1,
    input  logic [FW-1:0] axis_a2,
    input  logic [FW-1:0] axis_b0,
    input  logic [FW-1:0] axis_b1,
    input  logic [FW-1:0] axis_b2,
    input  logic [FW-1:0] extents_a,
    input  logic [FW-1:0] extents_b,
    output proj_t         pa    [3],
    output proj_t         pb    [3],
    output rot_t          r     [3][3],
    output ucomp_t        ea    [3],
    output ucomp_t        eb    [3]
);
    // stage 1 registers: unpacked components and center difference
    diff_t  d_reg  [3];
    comp_t  ax_reg [3][3];
    comp_t  bx_reg [3][3];
    ucomp_t a_reg  [3];
    ucomp_t b_reg  [3];
    // stage 2: one product per register, summed next stage
    logic signed [2*DW-1:0] pad_reg [3][3];
    logic signed [2*DW-1:0] pbd_reg [3][3];
    logic signed [2*W-1:0]  rr_reg  [3][3][3];
    ucomp_t a2_reg [3];
    ucomp_t b2_reg [3];

    logic [FW-1:0] axa [3];
    logic [FW-1:0] axb [3];
    assign axa[0] = axis_a0;
    assign axa[1] = axis_a1;
    assign axa[2] = axis_a2;
    assign axb[0] = axis_b0;
    assign axb[1] = axis_b1;
    assign axb[2] = axis_b2;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                d_reg[k] <= diff_t'(get_s(center_b, k)) - diff_t'(get_s(center_a, k));
                a_reg[k] <= get_u(extents_a, k);
                b_reg[k] <= get_u(extents_b, k);
                for (int i = 0; i < 3; i++)
                begin
                    ax_reg[i][k] <= get_s(axa[i], k);
                    bx_reg[i][k] <= get_s(axb[i], k);
                end
            end
            for (int i = 0; i < 3; i++)
            begin
                a2_reg[i] <= a_reg[i];
                b2_reg[i] <= b_reg[i];
                for (int k = 0; k < 3; k++)
                begin
                    pad_reg[i][k] <= (2*DW)'(ax_reg[i][k]) * (2*DW)'(d_reg[k]);
                    pbd_reg[i][k] <= (2*DW)'(bx_reg[i][k]) * (2*DW)'(d_reg[k]);
                    for (int j = 0; j < 3; j++)
                        rr_reg[i][j][k] <= (2*W)'(ax_reg[i][k]) * (2*W)'(bx_reg[j][k]);
                end
            end
        end
    end

    // sums and floor; registered by the next module
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pa[i] = PW'(pad_reg[i][0]) + PW'(pad_reg[i][1]) + PW'(pad_reg[i][2]);
            pb[i] = PW'(pbd_reg[i][0]) + PW'(pbd_reg[i][1]) + PW'(pbd_reg[i][2]);
            ea[i] = a2_reg[i];
            eb[i] = b2_reg[i];
            for (int j = 0; j < 3; j++)
                r[i][j] = rot_t'(((2*W+2)'(rr_reg[i][j][0]) + (2*W+2)'(rr_reg[i][j][1])
                          + (2*W+2)'(rr_reg[i][j][2])) >>> AF);
        end
    end
endmodule

// ===== design/obb_sat_test.sv =====
// ----------------------------------------------------------------------------
// obb_sat_test
// Stages 3-5: projections and radii products, sums, compares, priority pick.
// ----------------------------------------------------------------------------
module obb_sat_test
    import obb_sat_pkg::*;
(
    input  logic     clk,
    input  logic     en,
    input  proj_t    pa [3],
    input  proj_t    pb [3],
    input  rot_t     r  [3][3],
    input  ucomp_t   ea [3],
    input  ucomp_t   eb [3],
    output axis_id_t axis_id
);
    // stage 3: registered dot products
    proj_t  pa_reg [3];
    proj_t  pb_reg [3];
    rot_t   r_reg  [3][3];
    urot_t  c_reg  [3][3];
    ucomp_t a_reg  [3];
    ucomp_t b_reg  [3];
    // stage 4: products
    sum_t   ab_reg [3][3];   // a_i * c_ij
    sum_t   bb_reg [3][3];   // b_j * c_ij
    sum_t   xr_reg [3][3][4]; // edge radius terms for axis Ai x Bj
    prod_t  e_reg  [3][3][2];
    logic [PW-1:0] apa_reg [3];
    logic [PW-1:0] apb_reg [3];
    ucomp_t a4_reg [3];
    ucomp_t b4_reg [3];
    // stage 5: compare results
    logic [14:0] sep_reg;

    tproj_t t [3];

    function automatic logic edge_sep(input prod_t p, input prod_t q, input sum_t rhs);
        logic signed [LW-1:0] dv;
        lhs_t                 av;
        dv = LW'(p) - LW'(q);
        av = dv[LW-1] ? lhs_t'(-dv) : lhs_t'(dv);
        return (LW+SW)'(av) > (LW+SW)'(rhs);
    endfunction

    always_comb
        for (int i = 0; i < 3; i++)
            t[i] = tproj_t'(pa_reg[i] >>> AF);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pa_reg[i] <= pa[i];
                pb_reg[i] <= pb[i];
                a_reg[i]  <= ea[i];
                b_reg[i]  <= eb[i];
                for (int j = 0; j < 3; j++)
                begin
                    r_reg[i][j] <= r[i][j];
                    c_reg[i][j] <= r[i][j][RW-1] ? urot_t'(-r[i][j]) : urot_t'(r[i][j]);
                end
            end
            for (int i = 0; i < 3; i++)
            begin
                apa_reg[i] <= pa_reg[i][PW-1] ? PW'(-pa_reg[i]) : PW'(pa_reg[i]);
                apb_reg[i] <= pb_reg[i][PW-1] ? PW'(-pb_reg[i]) : PW'(pb_reg[i]);
                a4_reg[i]  <= a_reg[i];
                b4_reg[i]  <= b_reg[i];
                for (int j = 0; j < 3; j++)
                begin
                    ab_reg[i][j] <= SW'(a_reg[i]) * SW'(c_reg[i][j]);
                    bb_reg[i][j] <= SW'(b_reg[j]) * SW'(c_reg[i][j]);
                    xr_reg[i][j][0] <= SW'(a_reg[(i+1)%3]) * SW'(c_reg[(i+2)%3][j]);
                    xr_reg[i][j][1] <= SW'(a_reg[(i+2)%3]) * SW'(c_reg[(i+1)%3][j]);
                    xr_reg[i][j][2] <= SW'(b_reg[(j+1)%3]) * SW'(c_reg[i][(j+2)%3]);
                    xr_reg[i][j][3] <= SW'(b_reg[(j+2)%3]) * SW'(c_reg[i][(j+1)%3]);
                    e_reg[i][j][0] <= MW'(t[(i+2)%3]) * MW'(r_reg[(i+1)%3][j]);
                    e_reg[i][j][1] <= MW'(t[(i+1)%3]) * MW'(r_reg[(i+2)%3][j]);
                end
            end
            for (int i = 0; i < 3; i++)
            begin
                sep_reg[i] <= {1'b0, apa_reg[i]} >
                    (PW+1)'((SW'(a4_reg[i]) << AF) + bb_reg[i][0] + bb_reg[i][1]
                    + bb_reg[i][2]);
                sep_reg[3+i] <= {1'b0, apb_reg[i]} >
                    (PW+1)'((SW'(b4_reg[i]) << AF) + ab_reg[0][i] + ab_reg[1][i]
                    + ab_reg[2][i]);
            end
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    sep_reg[6+3*i+j] <= edge_sep(e_reg[i][j][0], e_reg[i][j][1],
                        xr_reg[i][j][0] + xr_reg[i][j][1]
                        + xr_reg[i][j][2] + xr_reg[i][j][3]);
        end
    end

    // first set bit in table order
    always_comb
    begin
        axis_id = AXIS_NONE;
        for (int k = 14; k >= 0; k--)
            if (sep_reg[k])
                axis_id = axis_id_t'(k + 1);
    end
endmodule
